// ===== rtl/ibsm_pkg.sv =====
// Shared types and constants for the inactivity and battery shutdown monitor.
// No dependencies; the files that use it refer to this package by scoped name.
package ibsm_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BATTERY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TMO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERACT_TMO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BATTERY_GRACE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_LEAD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPREAD    = 3'd5;

    // Register reset values
    localparam logic [12:0] RST_MIN_BATTERY   = 13'd3200;
    localparam logic [30:0] RST_ACTIVE_TMO    = 31'd300000;
    localparam logic [30:0] RST_INTERACT_TMO  = 31'd60000;
    localparam logic [30:0] RST_BATTERY_GRACE = 31'd10000;
    localparam logic [30:0] RST_ALERT_LEAD    = 31'd5000;
    localparam logic [30:0] RST_MAX_SPREAD    = 31'd450;

    // Shutdown reason codes
    localparam logic [1:0] REASON_NONE    = 2'd0;
    localparam logic [1:0] REASON_INACT   = 2'd1;
    localparam logic [1:0] REASON_BATTERY = 2'd2;

    // One stored position fix
    typedef struct packed {
        logic signed [30:0] lat;
        logic signed [31:0] lon;
    } fix_t;

    // Control from the sequencer to the spread accumulator
    typedef struct packed {
        logic sample;  // take the tail fix this cycle
        logic first;   // first fix of a walk: seed the extremes
    } walk_ctl_t;

endpackage

// ===== rtl/ibsm_update_if.sv =====
// Update request channel of the shutdown monitor: valid/ready plus payload.
// Depends on nothing.
interface ibsm_update_if;
    logic               valid;
    logic               ready;
    logic [31:0]        now_ms;
    logic [31:0]        last_touch_ms;
    logic               gps_valid;
    logic [31:0]        gps_stamp;
    logic signed [30:0] latitude;
    logic signed [31:0] longitude;
    logic [12:0]        battery_mv;

    modport source (
        output valid, now_ms, last_touch_ms, gps_valid, gps_stamp,
               latitude, longitude, battery_mv,
        input  ready
    );
    modport sink (
        input  valid, now_ms, last_touch_ms, gps_valid, gps_stamp,
               latitude, longitude, battery_mv,
        output ready
    );
endinterface

// ===== rtl/ibsm_result_if.sv =====
// Result request channel of the shutdown monitor: valid/ready plus payload.
// Depends on nothing.
interface ibsm_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] shutdown_reason;
    logic       power_off;
    logic       in_motion;

    modport source (
        output valid, shutdown_reason, power_off, in_motion,
        input  ready
    );
    modport sink (
        input  valid, shutdown_reason, power_off, in_motion,
        output ready
    );
endinterface

// ===== rtl/ibsm_cell.sv =====
// One cell of the fix history chain: holds a single position fix.
// Depends on ibsm_pkg for fix_t.
module ibsm_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  ibsm_pkg::fix_t  d_in,
    output ibsm_pkg::fix_t  d_out
);

    ibsm_pkg::fix_t fix_reg;

    // Take the neighbour's fix when the chain moves; history starts at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix_reg <= '0;
        end
        else if (en)
        begin
            fix_reg <= d_in;
        end
    end

    assign d_out = fix_reg;

endmodule

// ===== rtl/ibsm_spread.sv =====
// Latitude and longitude extremes accumulated one fix per cycle from the
// tail of the history chain, and the still/moving decision against max_spread.
// Depends on ibsm_pkg for fix_t and walk_ctl_t.
module ibsm_spread (
    input  logic                clk,
    input  logic                rst_n,
    input  ibsm_pkg::walk_ctl_t ctl,
    input  ibsm_pkg::fix_t      sample,
    input  logic [30:0]         max_spread,
    output logic                still
);

    logic signed [30:0] lat_lo_reg, lat_lo_next;
    logic signed [30:0] lat_hi_reg, lat_hi_next;
    logic signed [31:0] lon_lo_reg, lon_lo_next;
    logic signed [31:0] lon_hi_reg, lon_hi_next;
    logic [31:0]        lat_span;
    logic [32:0]        lon_span;

    // Seed on the first fix, then widen the extremes
    always_comb
    begin
        lat_lo_next = lat_lo_reg;
        lat_hi_next = lat_hi_reg;
        lon_lo_next = lon_lo_reg;
        lon_hi_next = lon_hi_reg;
        if (ctl.first)
        begin
            lat_lo_next = sample.lat;
            lat_hi_next = sample.lat;
            lon_lo_next = sample.lon;
            lon_hi_next = sample.lon;
        end
        else
        begin
            if (sample.lat < lat_lo_reg) lat_lo_next = sample.lat;
            if (sample.lat > lat_hi_reg) lat_hi_next = sample.lat;
            if (sample.lon < lon_lo_reg) lon_lo_next = sample.lon;
            if (sample.lon > lon_hi_reg) lon_hi_next = sample.lon;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_lo_reg <= '0;
            lat_hi_reg <= '0;
            lon_lo_reg <= '0;
            lon_hi_reg <= '0;
        end
        else if (ctl.sample)
        begin
            lat_lo_reg <= lat_lo_next;
            lat_hi_reg <= lat_hi_next;
            lon_lo_reg <= lon_lo_next;
            lon_hi_reg <= lon_hi_next;
        end
    end

    // Spreads are never negative, so compare them unsigned
    assign lat_span = {lat_hi_reg[30], lat_hi_reg} - {lat_lo_reg[30], lat_lo_reg};
    assign lon_span = {lon_hi_reg[31], lon_hi_reg} - {lon_lo_reg[31], lon_lo_reg};
    assign still    = (lat_span < {1'b0, max_spread}) && (lon_span < {2'b00, max_spread});

endmodule

// ===== rtl/inactivity_battery_shutdown_monitor.sv =====
// Inactivity and battery shutdown monitor, top level.
// Depends on ibsm_pkg, ibsm_update_if, ibsm_result_if, ibsm_cell, ibsm_spread.
//
// Usage: each update request (time, last touch, GPS fix, battery voltage)
// on the update channel gives exactly one result request on the result
// channel: shutdown reason, power-off flag and motion flag. Registers are
// written through cfg_we/cfg_index/cfg_data; the user must do so while the
// block is idle, as the block itself does not enforce it; indexes past the
// last register are ignored.
// An update carrying a new valid fix walks the fix history chain, one cell
// per cycle through a single min/max unit, then passes the check, deadline
// and finish steps; any other update goes straight to the deadline and
// finish steps. One update is worked on at a time: the next one is taken
// once the previous result is loaded into the output register.
// A stalled result is held in the output register; the next update is still
// taken and waits at its final step until the register frees up.
// Reset clears the history to zero, the deadlines to their initial values
// and the registers to their defaults; no clearing pass is needed.
module inactivity_battery_shutdown_monitor #(
    parameter int HISTORY_DEPTH = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    ibsm_update_if.sink                         update,
    ibsm_result_if.source                       result,
    input  logic                                cfg_we,
    input  logic [ibsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ibsm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CNT_W = (HISTORY_DEPTH > 2) ? $clog2(HISTORY_DEPTH) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WALK   = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_DEADLN = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    // Configuration registers
    logic [12:0] min_battery_reg;
    logic [30:0] active_tmo_reg;
    logic [30:0] interact_tmo_reg;
    logic [30:0] battery_grace_reg;
    logic [30:0] alert_lead_reg;
    logic [30:0] max_spread_reg;

    // Sequencer and per-update state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] walk_cnt_reg, walk_cnt_next;
    logic [31:0]      now_reg;
    logic [31:0]      touch_reg;
    logic [12:0]      batt_reg;
    logic             moving_reg, moving_next;
    logic [31:0]      last_stamp_reg;
    logic [31:0]      act_deadline_reg;
    logic [31:0]      bat_deadline_reg;

    // Output register
    logic             out_valid_reg;
    logic [1:0]       out_reason_reg;
    logic             out_power_reg;
    logic             out_motion_reg;

    // Datapath signals
    logic                accept;
    logic                new_fix;
    logic                walking;
    logic                chain_en;
    logic                still;
    logic                out_free;
    logic                interacting;
    logic                lead_bat_low;
    logic                lead_act_low;
    logic [31:0]         earliest;
    logic [1:0]          reason;
    ibsm_pkg::fix_t      head_fix;
    ibsm_pkg::fix_t      new_fix_data;
    ibsm_pkg::fix_t      chain_q [HISTORY_DEPTH];
    ibsm_pkg::walk_ctl_t walk_ctl;

    assign accept       = update.valid && update.ready;
    assign new_fix      = update.gps_valid && (update.gps_stamp != last_stamp_reg);
    assign walking      = (state_reg == ST_WALK);
    assign out_free     = !out_valid_reg || result.ready;
    assign update.ready = (state_reg == ST_IDLE);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_battery_reg   <= ibsm_pkg::RST_MIN_BATTERY;
            active_tmo_reg    <= ibsm_pkg::RST_ACTIVE_TMO;
            interact_tmo_reg  <= ibsm_pkg::RST_INTERACT_TMO;
            battery_grace_reg <= ibsm_pkg::RST_BATTERY_GRACE;
            alert_lead_reg    <= ibsm_pkg::RST_ALERT_LEAD;
            max_spread_reg    <= ibsm_pkg::RST_MAX_SPREAD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ibsm_pkg::REG_MIN_BATTERY:   min_battery_reg   <= cfg_data[12:0];
                ibsm_pkg::REG_ACTIVE_TMO:    active_tmo_reg    <= cfg_data;
                ibsm_pkg::REG_INTERACT_TMO:  interact_tmo_reg  <= cfg_data;
                ibsm_pkg::REG_BATTERY_GRACE: battery_grace_reg <= cfg_data;
                ibsm_pkg::REG_ALERT_LEAD:    alert_lead_reg    <= cfg_data;
                ibsm_pkg::REG_MAX_SPREAD:    max_spread_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Fix history chain: shift a new fix in at the head, or rotate during a walk
    assign new_fix_data.lat = update.latitude;
    assign new_fix_data.lon = update.longitude;
    assign head_fix = walking ? chain_q[HISTORY_DEPTH-1] : new_fix_data;
    assign chain_en = walking || (accept && new_fix);

    genvar gi;
    generate
        for (gi = 0; gi < HISTORY_DEPTH; gi++)
        begin : g_chain
            if (gi == 0)
            begin : g_head
                ibsm_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .en    (chain_en),
                    .d_in  (head_fix),
                    .d_out (chain_q[gi])
                );
            end
            else
            begin : g_body
                ibsm_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .en    (chain_en),
                    .d_in  (chain_q[gi-1]),
                    .d_out (chain_q[gi])
                );
            end
        end
    endgenerate

    // Min/max over the fixes leaving the tail
    assign walk_ctl.sample = walking;
    assign walk_ctl.first  = walking && (walk_cnt_reg == '0);

    ibsm_spread u_spread (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (walk_ctl),
        .sample     (chain_q[HISTORY_DEPTH-1]),
        .max_spread (max_spread_reg),
        .still      (still)
    );

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        walk_cnt_next = walk_cnt_reg;
        moving_next   = moving_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    moving_next   = !update.gps_valid;
                    walk_cnt_next = '0;
                    state_next    = new_fix ? ST_WALK : ST_DEADLN;
                end
            end
            ST_WALK:
            begin
                walk_cnt_next = walk_cnt_reg + 1'b1;
                if (walk_cnt_reg == CNT_W'(HISTORY_DEPTH - 1))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                moving_next = !still;
                state_next  = ST_DEADLN;
            end
            ST_DEADLN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            walk_cnt_reg   <= '0;
            moving_reg     <= 1'b0;
            last_stamp_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            walk_cnt_reg <= walk_cnt_next;
            moving_reg   <= moving_next;
            if (accept && new_fix)
            begin
                last_stamp_reg <= update.gps_stamp;
            end
        end
    end

    // Hold the update's scalar fields while it is worked on
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg   <= update.now_ms;
            touch_reg <= update.last_touch_ms;
            batt_reg  <= update.battery_mv;
        end
    end

    // Extend deadlines
    assign interacting = (now_reg - touch_reg) < {1'b0, interact_tmo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_deadline_reg <= {1'b0, ibsm_pkg::RST_ACTIVE_TMO};
            bat_deadline_reg <= {1'b0, ibsm_pkg::RST_BATTERY_GRACE};
        end
        else if (state_reg == ST_DEADLN)
        begin
            if (moving_reg || interacting)
            begin
                act_deadline_reg <= now_reg + {1'b0, active_tmo_reg};
            end
            if (batt_reg >= min_battery_reg)
            begin
                bat_deadline_reg <= now_reg + {1'b0, battery_grace_reg};
            end
        end
    end

    // Remaining lead read as signed, battery reason first
    assign lead_bat_low = $signed(bat_deadline_reg - now_reg)
                          < $signed({1'b0, alert_lead_reg});
    assign lead_act_low = $signed(act_deadline_reg - now_reg)
                          < $signed({1'b0, alert_lead_reg});
    assign reason = lead_bat_low ? ibsm_pkg::REASON_BATTERY :
                    lead_act_low ? ibsm_pkg::REASON_INACT   :
                                   ibsm_pkg::REASON_NONE;
    assign earliest = (act_deadline_reg < bat_deadline_reg) ? act_deadline_reg
                                                            : bat_deadline_reg;

    // Output register: load on finish, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_FINISH) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_reason_reg <= reason;
            out_power_reg  <= (now_reg > earliest);
            out_motion_reg <= moving_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.shutdown_reason = out_reason_reg;
    assign result.power_off       = out_power_reg;
    assign result.in_motion       = out_motion_reg;

endmodule

// ===== rtl/ibsm_checker.sv =====
// Port-level checks for the shutdown monitor, bound to the top level.
// Depends on the top level's ports only.
module ibsm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       upd_valid,
    input logic       upd_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] res_reason,
    input logic       res_power,
    input logic       res_motion
);

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_reason)
            && $stable(res_power) && $stable(res_motion))
        else $error("stalled result changed");

    // One update at a time: ready drops after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        upd_valid && upd_ready |=> !upd_ready)
        else $error("update taken while busy");

    // A result never appears the cycle after its update is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        upd_valid && upd_ready |=> !$rose(res_valid))
        else $error("result too early");

    // Reason code 3 is never produced
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_reason != 2'd3)
        else $error("bad shutdown reason");

endmodule

bind inactivity_battery_shutdown_monitor ibsm_checker u_ibsm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd_valid  (update.valid),
    .upd_ready  (update.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_reason (result.shutdown_reason),
    .res_power  (result.power_off),
    .res_motion (result.in_motion)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the inactivity and battery shutdown monitor: a directed table, then
// random update phases under several register settings. Depends on ibsm_pkg, both channel ifs and the top.
module tb_top;

    localparam int HIST        = 10;
    localparam int HOLD_AT     = 500;   // result count at which the receiver backs off
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic [31:0]        last_touch_ms;
        logic               gps_valid;
        logic [31:0]        gps_stamp;
        logic signed [30:0] latitude;
        logic signed [31:0] longitude;
        logic [12:0]        battery_mv;
    } upd_t;

    typedef struct packed {
        logic [1:0] reason;
        logic       power_off;
        logic       in_motion;
    } verdict_t;

    typedef struct packed {
        upd_t     upd;
        bit       typed;
        verdict_t want;
    } probe_t;

    localparam verdict_t UNTYPED = '0;

    // Directed updates; rows with typed set carry a hand-worked result
    localparam probe_t PROBES [24] = '{
        // after reset, no fix: moving, deadlines far off
        '{'{32'd0, 32'd0, 1'b0, 32'd0, 31'sd0, 32'sd0, 13'd8191},
          1'b1, '{ibsm_pkg::REASON_NONE, 1'b0, 1'b1}},
        // valid fix with the reset stamp: still, ring untouched
        '{'{32'd1000, 32'd0, 1'b1, 32'd0, 31'h3FFF_FFFF, 32'h7FFF_FFFF, 13'd0},
          1'b1, '{ibsm_pkg::REASON_NONE, 1'b0, 1'b0}},
        // battery just below the minimum, inside the alert lead
        '{'{32'd6000, 32'd0, 1'b1, 32'd0, 31'sd0, 32'sd0, 13'd3199},
          1'b1, '{ibsm_pkg::REASON_BATTERY, 1'b0, 1'b0}},
        // battery deadline passed
        '{'{32'd20000, 32'd0, 1'b1, 32'd0, 31'sd0, 32'sd0, 13'd3199},
          1'b1, '{ibsm_pkg::REASON_BATTERY, 1'b1, 1'b0}},
        // battery exactly at the minimum counts good
        '{'{32'd21000, 32'd0, 1'b1, 32'd0, 31'sd0, 32'sd0, 13'd3200},
          1'b1, '{ibsm_pkg::REASON_NONE, 1'b0, 1'b0}},
        // new fix at the most negative position against the zeroed ring
        '{'{32'd22000, 32'd0, 1'b1, 32'd1, 31'h4000_0000, 32'h8000_0000, 13'd8191},
          1'b1, '{ibsm_pkg::REASON_NONE, 1'b0, 1'b1}},
        // fill the rest of the ring with one position
        '{'{32'd23000, 32'd0, 1'b1, 32'd2, 31'sd1000, -32'sd1000, 13'd8191}, 1'b0, UNTYPED},
        '{'{32'd24000, 32'd0, 1'b1, 32'd3, 31'sd1000, -32'sd1000, 13'd8191}, 1'b0, UNTYPED},
        '{'{32'd25000, 32'd0, 1'b1, 32'd4, 31'sd1000, -32'sd1000, 13'd8191}, 1'b0, UNTYPED},
        '{'{32'd26000, 32'd0, 1'b1, 32'd5, 31'sd1000, -32'sd1000, 13'd8191}, 1'b0, UNTYPED},
        '{'{32'd27000, 32'd0, 1'b1, 32'd6, 31'sd1000, -32'sd1000, 13'd8191}, 1'b0, UNTYPED},
        '{'{32'd28000, 32'd0, 1'b1, 32'd7, 31'sd1000, -32'sd1000, 13'd8191}, 1'b0, UNTYPED},
        '{'{32'd29000, 32'd0, 1'b1, 32'd8, 31'sd1000, -32'sd1000, 13'd8191}, 1'b0, UNTYPED},
        '{'{32'd30000, 32'd0, 1'b1, 32'd9, 31'sd1000, -32'sd1000, 13'd8191}, 1'b0, UNTYPED},
        '{'{32'd31000, 32'd0, 1'b1, 32'd10, 31'sd1000, -32'sd1000, 13'd8191}, 1'b0, UNTYPED},
        // overwrite the oldest entry: spread one below the threshold
        '{'{32'd32000, 32'd0, 1'b1, 32'd11, 31'sd1449, -32'sd1000, 13'd8191}, 1'b0, UNTYPED},
        // spread exactly at the threshold
        '{'{32'd33000, 32'd0, 1'b1, 32'd12, 31'sd999, -32'sd1000, 13'd8191}, 1'b0, UNTYPED},
        // touch exactly one window back, then one below
        '{'{32'd100000, 32'd40000, 1'b1, 32'd12, 31'sd0, 32'sd0, 13'd8191}, 1'b0, UNTYPED},
        '{'{32'd101000, 32'd41001, 1'b1, 32'd12, 31'sd0, 32'sd0, 13'd8191}, 1'b0, UNTYPED},
        // touch stamp ahead of now wraps to a huge age
        '{'{32'd200000, 32'd200001, 1'b1, 32'd12, 31'sd0, 32'sd0, 13'd8191}, 1'b0, UNTYPED},
        // still and idle long enough for the activity deadline to pass
        '{'{32'd700000, 32'd0, 1'b1, 32'd12, 31'sd0, 32'sd0, 13'd8191},
          1'b1, '{ibsm_pkg::REASON_INACT, 1'b1, 1'b0}},
        // deadlines wrap past 2^32: lead stays positive, power-off still raised
        '{'{32'hFFFF_FFF0, 32'hFFFF_FFF0, 1'b0, 32'd0, 31'sd0, 32'sd0, 13'd8191},
          1'b1, '{ibsm_pkg::REASON_NONE, 1'b1, 1'b1}},
        // no fix but a fresh stamp: ring untouched
        '{'{32'd5000, 32'd0, 1'b0, 32'd99, 31'sd5, 32'sd5, 13'd4000}, 1'b0, UNTYPED},
        // stamp back to zero is still a change
        '{'{32'd6000, 32'd0, 1'b1, 32'd0, 31'h3FFF_FFFF, 32'h7FFF_FFFF, 13'd4000}, 1'b0, UNTYPED}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic                            cfg_we;
    logic [ibsm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ibsm_pkg::CFG_DATA_W-1:0] cfg_data;

    ibsm_update_if upd_ch();
    ibsm_result_if res_ch();

    inactivity_battery_shutdown_monitor #(.HISTORY_DEPTH(HIST)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .update    (upd_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Shadow registers and monitor state
    logic [12:0] min_batt     = ibsm_pkg::RST_MIN_BATTERY;
    logic [30:0] active_tmo   = ibsm_pkg::RST_ACTIVE_TMO;
    logic [30:0] interact_tmo = ibsm_pkg::RST_INTERACT_TMO;
    logic [30:0] batt_grace   = ibsm_pkg::RST_BATTERY_GRACE;
    logic [30:0] alert_lead   = ibsm_pkg::RST_ALERT_LEAD;
    logic [30:0] max_spread   = ibsm_pkg::RST_MAX_SPREAD;
    longint      fix_lat [HIST] = '{default: 0};
    longint      fix_lon [HIST] = '{default: 0};
    int          fix_ptr      = 0;
    logic [31:0] fix_stamp    = '0;
    logic [31:0] act_deadline = 32'(ibsm_pkg::RST_ACTIVE_TMO);
    logic [31:0] bat_deadline = 32'(ibsm_pkg::RST_BATTERY_GRACE);

    verdict_t verdicts_due [$];
    int mismatches = 0;
    int sent = 0;

    // Random stimulus state
    logic [31:0] t_now = '0;
    logic [31:0] t_touch = '0;
    logic [31:0] t_stamp = '0;
    longint      base_lat = 0;
    longint      base_lon = 0;

    function automatic bit lead_short(logic [31:0] deadline, logic [31:0] now);
        logic signed [31:0] lead;
        lead = deadline - now;
        return longint'(lead) < longint'(alert_lead);
    endfunction

    // Advance the shadow monitor by one update and return its verdict
    function automatic verdict_t judge_update(upd_t u);
        verdict_t    v;
        bit          moving;
        bit          interacting;
        longint      lat_lo, lat_hi, lon_lo, lon_hi;
        logic [31:0] earliest;
        moving = !u.gps_valid;
        if (u.gps_valid && u.gps_stamp != fix_stamp)
        begin
            fix_lat[fix_ptr] = longint'(u.latitude);
            fix_lon[fix_ptr] = longint'(u.longitude);
            fix_ptr = (fix_ptr == HIST - 1) ? 0 : fix_ptr + 1;
            lat_lo = fix_lat[0];
            lat_hi = fix_lat[0];
            lon_lo = fix_lon[0];
            lon_hi = fix_lon[0];
            for (int i = 1; i < HIST; i++)
            begin
                if (fix_lat[i] < lat_lo) lat_lo = fix_lat[i];
                if (fix_lat[i] > lat_hi) lat_hi = fix_lat[i];
                if (fix_lon[i] < lon_lo) lon_lo = fix_lon[i];
                if (fix_lon[i] > lon_hi) lon_hi = fix_lon[i];
            end
            fix_stamp = u.gps_stamp;
            moving = !((lat_hi - lat_lo) < longint'(max_spread) &&
                       (lon_hi - lon_lo) < longint'(max_spread));
        end
        interacting = 32'(u.now_ms - u.last_touch_ms) < {1'b0, interact_tmo};
        if (moving || interacting)
            act_deadline = u.now_ms + {1'b0, active_tmo};
        if (u.battery_mv >= min_batt)
            bat_deadline = u.now_ms + {1'b0, batt_grace};
        if (lead_short(bat_deadline, u.now_ms))
            v.reason = ibsm_pkg::REASON_BATTERY;
        else if (lead_short(act_deadline, u.now_ms))
            v.reason = ibsm_pkg::REASON_INACT;
        else
            v.reason = ibsm_pkg::REASON_NONE;
        earliest = (act_deadline < bat_deadline) ? act_deadline : bat_deadline;
        v.power_off = u.now_ms > earliest;
        v.in_motion = moving;
        return v;
    endfunction

    // Offer one update after a random gap; predict its verdict on acceptance
    task automatic present_update(input upd_t u, input bit typed, input verdict_t typed_want);
        int       gap;
        verdict_t predicted;
        gap = (sent % 64 < 16) ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            upd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        upd_ch.valid         <= 1'b1;
        upd_ch.now_ms        <= u.now_ms;
        upd_ch.last_touch_ms <= u.last_touch_ms;
        upd_ch.gps_valid     <= u.gps_valid;
        upd_ch.gps_stamp     <= u.gps_stamp;
        upd_ch.latitude      <= u.latitude;
        upd_ch.longitude     <= u.longitude;
        upd_ch.battery_mv    <= u.battery_mv;
        do @(posedge clk); while (!upd_ch.ready);
        predicted = judge_update(u);
        verdicts_due.push_back(typed ? typed_want : predicted);
        sent++;
        @(negedge clk);
    endtask

    // Drop valid and hold until every outstanding verdict has come back
    task automatic settle();
        upd_ch.valid <= 1'b0;
        do @(posedge clk); while (verdicts_due.size() != 0);
        @(negedge clk);
    endtask

    // Write all registers plus the two unused indexes, one per cycle
    task automatic load_regs(input logic [30:0] vals [8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(negedge clk);
            case (3'(i))
                ibsm_pkg::REG_MIN_BATTERY:   min_batt     = vals[i][12:0];
                ibsm_pkg::REG_ACTIVE_TMO:    active_tmo   = vals[i];
                ibsm_pkg::REG_INTERACT_TMO:  interact_tmo = vals[i];
                ibsm_pkg::REG_BATTERY_GRACE: batt_grace   = vals[i];
                ibsm_pkg::REG_ALERT_LEAD:    alert_lead   = vals[i];
                ibsm_pkg::REG_MAX_SPREAD:    max_spread   = vals[i];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    // Random updates: mostly a device wandering around one spot on a running clock
    task automatic run_phase(input int n_items);
        upd_t u;
        int   pick;
        int   jit;
        int   batt;
        for (int k = 0; k < n_items; k++)
        begin
            if (k == n_items / 2)
                settle();
            case ($urandom_range(0, 9))
                0:       t_now = $urandom;
                1, 2:    t_now = t_now + $urandom_range(0, 400000);
                default: t_now = t_now + $urandom_range(0, 20000);
            endcase
            case ($urandom_range(0, 4))
                0:       t_touch = $urandom;
                1, 2:    t_touch = t_now - $urandom_range(0, 120000);
                default: ;
            endcase
            u.now_ms = t_now;
            u.last_touch_ms = t_touch;
            pick = $urandom_range(0, 9);
            if (pick < 2)
            begin
                u.gps_valid = 1'b0;
                u.gps_stamp = $urandom_range(0, 1) ? t_stamp : 32'($urandom);
            end
            else
            begin
                if (pick >= 4)
                    t_stamp = ($urandom_range(0, 7) == 0) ? 32'($urandom) : t_stamp + 1;
                u.gps_valid = 1'b1;
                u.gps_stamp = t_stamp;
            end
            pick = $urandom_range(0, 19);
            if (pick < 2)
            begin
                u.latitude  = 31'($urandom);
                u.longitude = 32'($urandom);
            end
            else
            begin
                if (pick == 2)
                begin
                    base_lat = longint'($urandom_range(0, 1800000000)) - 900000000;
                    base_lon = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
                end
                jit = $urandom_range(0, 300);
                u.latitude  = 31'(base_lat + $urandom_range(0, 2 * jit) - jit);
                u.longitude = 32'(base_lon + $urandom_range(0, 2 * jit) - jit);
            end
            if ($urandom_range(0, 9) < 6)
            begin
                batt = int'(min_batt) + $urandom_range(0, 100) - 50;
                batt = (batt < 0) ? 0 : (batt > 8191) ? 8191 : batt;
                u.battery_mv = 13'(batt);
            end
            else
                u.battery_mv = 13'($urandom_range(0, 8191));
            present_update(u, 1'b0, UNTYPED);
        end
        settle();
    endtask

    // Result side: random stalls, one long back-off, check against the oldest verdict
    initial
    begin : result_sink
        int       gap;
        int       taken;
        verdict_t seen;
        verdict_t want;
        taken = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (taken == HOLD_AT)
                gap = HOLD_CYCLES;
            else
                gap = ((taken + 32) % 64 < 16) ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            seen = '{res_ch.shutdown_reason, res_ch.power_off, res_ch.in_motion};
            taken++;
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: result %0d with no update pending: reason %0d off %0b motion %0b",
                         $time, taken, seen.reason, seen.power_off, seen.in_motion);
                mismatches++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (seen.reason !== want.reason)
                begin
                    $display("%0t: result %0d shutdown_reason expected %0d got %0d",
                             $time, taken, want.reason, seen.reason);
                    mismatches++;
                end
                if (seen.power_off !== want.power_off)
                begin
                    $display("%0t: result %0d power_off expected %0b got %0b",
                             $time, taken, want.power_off, seen.power_off);
                    mismatches++;
                end
                if (seen.in_motion !== want.in_motion)
                begin
                    $display("%0t: result %0d in_motion expected %0b got %0b",
                             $time, taken, want.in_motion, seen.in_motion);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random phases under changing registers
    initial
    begin : update_source
        logic [30:0] regs_next [8];
        upd_ch.valid         <= 1'b0;
        upd_ch.now_ms        <= '0;
        upd_ch.last_touch_ms <= '0;
        upd_ch.gps_valid     <= 1'b0;
        upd_ch.gps_stamp     <= '0;
        upd_ch.latitude      <= '0;
        upd_ch.longitude     <= '0;
        upd_ch.battery_mv    <= '0;
        cfg_we               <= 1'b0;
        cfg_index            <= '0;
        cfg_data             <= '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (PROBES[i])
            present_update(PROBES[i].upd, PROBES[i].typed, PROBES[i].want);
        settle();

        // all registers at zero
        regs_next = '{default: '0};
        regs_next[6] = 31'($urandom);
        regs_next[7] = 31'($urandom);
        load_regs(regs_next);
        run_phase(200);

        // all registers at their top value; the battery write carries spare high bits
        regs_next = '{default: 31'h7FFF_FFFF};
        load_regs(regs_next);
        run_phase(200);

        // realistic values around the defaults
        for (int r = 0; r < 2; r++)
        begin
            regs_next[ibsm_pkg::REG_MIN_BATTERY]   = 31'($urandom_range(2800, 3600));
            regs_next[ibsm_pkg::REG_ACTIVE_TMO]    = 31'($urandom_range(1000, 400000));
            regs_next[ibsm_pkg::REG_INTERACT_TMO]  = 31'($urandom_range(0, 120000));
            regs_next[ibsm_pkg::REG_BATTERY_GRACE] = 31'($urandom_range(0, 50000));
            regs_next[ibsm_pkg::REG_ALERT_LEAD]    = 31'($urandom_range(0, 20000));
            regs_next[ibsm_pkg::REG_MAX_SPREAD]    = 31'($urandom_range(0, 1500));
            regs_next[6] = 31'($urandom);
            regs_next[7] = 31'($urandom);
            load_regs(regs_next);
            run_phase(200);

            // every bit of every register at random
            if (r == 0)
            begin
                foreach (regs_next[i])
                    regs_next[i] = 31'($urandom);
                load_regs(regs_next);
                run_phase(200);
            end
        end

        settle();
        repeat (HIST + 3) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
